### src/hjg_pkg.sv
// ----------------------------------------------------------------------------
// hjg_pkg - shared constants and types for the Halton jitter generator
// Widths, the base-3 reciprocal and the cell payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hjg_pkg;

  // Index width and number of fraction bits of the jitter values.
  localparam int INDEX_BITS  = 16;
  localparam int FRAC_BITS   = 24;

  // Output field width, fixed.
  localparam int OUT_BITS    = 24;

  // Ternary digits taken from the index, and the matching denominator 3^20.
  localparam int TERN_DIGITS = 20;
  localparam int TNUM_W      = 32;
  localparam logic [TNUM_W-1:0] TERN_DEN = 32'd3486784401;

  // Width used to centre a quotient before it wraps into OUT_BITS.
  localparam int CENTRE_W    = (FRAC_BITS > OUT_BITS) ? FRAC_BITS : OUT_BITS;

  // ceil(2^(INDEX_BITS+1) / 3): exact divide by three for any INDEX_BITS-bit value.
  localparam logic [INDEX_BITS-1:0] RECIP3 =
      INDEX_BITS'(((64'd1 << (INDEX_BITS + 1)) + 64'd2) / 64'd3);

  // Payload handed along the digit-extraction cells.
  typedef struct packed {
    logic [INDEX_BITS-1:0] v;     // index still to be split into digits
    logic [TNUM_W-1:0]     tnum;  // mirrored ternary numerator so far
    logic [OUT_BITS-1:0]   jx;    // finished x value, carried in step
  } tern_t;

  // Payload handed along the long-division cells.
  typedef struct packed {
    logic [TNUM_W-1:0]    rem;    // partial remainder, below TERN_DEN
    logic [FRAC_BITS-1:0] q;      // quotient bits so far
    logic [OUT_BITS-1:0]  jx;     // finished x value, carried in step
  } div_t;

endpackage

`default_nettype wire

### src/hjg_tern_cell.sv
// ----------------------------------------------------------------------------
// hjg_tern_cell - one ternary digit step
// Splits off the lowest base-3 digit and appends it to the mirrored numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module hjg_tern_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire hjg_pkg::tern_t data_i,
  output logic               valid_o,
  output hjg_pkg::tern_t     data_o
);

  logic [2*hjg_pkg::INDEX_BITS-1:0] prod;
  logic [hjg_pkg::INDEX_BITS-1:0]   quot;
  logic [hjg_pkg::INDEX_BITS-1:0]   back;
  logic [1:0]                       digit;
  logic                             valid_q;
  hjg_pkg::tern_t                   data_d, data_q;

  always_comb begin
    prod  = {{hjg_pkg::INDEX_BITS{1'b0}}, data_i.v}
          * {{hjg_pkg::INDEX_BITS{1'b0}}, hjg_pkg::RECIP3};
    quot  = hjg_pkg::INDEX_BITS'(prod >> (hjg_pkg::INDEX_BITS + 1));
    back  = (quot << 1) + quot;
    digit = 2'(data_i.v - back);
    data_d.v    = quot;
    data_d.tnum = (data_i.tnum << 1) + data_i.tnum
                + {{(hjg_pkg::TNUM_W-2){1'b0}}, digit};
    data_d.jx   = data_i.jx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/hjg_div_cell.sv
// ----------------------------------------------------------------------------
// hjg_div_cell - one restoring division step
// Doubles the remainder, subtracts 3^20 where it fits, shifts in a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hjg_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire hjg_pkg::div_t data_i,
  output logic               valid_o,
  output hjg_pkg::div_t      data_o
);

  logic [hjg_pkg::TNUM_W:0] dbl;
  logic                     fits;
  logic                     valid_q;
  hjg_pkg::div_t            data_d, data_q;

  always_comb begin
    dbl  = {data_i.rem, 1'b0};
    fits = (dbl >= {1'b0, hjg_pkg::TERN_DEN});
    data_d.rem = fits ? hjg_pkg::TNUM_W'(dbl - {1'b0, hjg_pkg::TERN_DEN})
                      : hjg_pkg::TNUM_W'(dbl);
    data_d.q   = {data_i.q[hjg_pkg::FRAC_BITS-2:0], fits};
    data_d.jx  = data_i.jx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/halton_jitter_generator_top.sv
// ----------------------------------------------------------------------------
// halton_jitter_generator_top - Halton (2,3) sub-pixel jitter pipeline
// Index in, centred base-2 / base-3 radical inverse pair out, one per cycle.
// ----------------------------------------------------------------------------
// One sample index is taken per clock and one jitter pair leaves per clock
// while the row is not stalled; each beat passes through a row of cells:
// one cell per ternary digit, then one cell per quotient bit of the
// division by 3^20. Both sides use valid/stall. The whole row moves
// together: it advances whenever the last cell is empty or the output is not
// stalled, so in_stall_o follows out_stall_i only while a result is waiting.
// Outputs are signed fixed point with FRAC_BITS fraction bits, floored, with
// one half subtracted; index zero gives minus one half on both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module halton_jitter_generator_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [hjg_pkg::INDEX_BITS-1:0]        sample_index_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [hjg_pkg::OUT_BITS-1:0]        jitter_x_o,
  output logic signed [hjg_pkg::OUT_BITS-1:0]        jitter_y_o
);

  localparam int ND = hjg_pkg::TERN_DIGITS;
  localparam int NF = hjg_pkg::FRAC_BITS;

  // Shared advance for every cell of the row.
  logic en;

  logic [ND:0]     tv;
  hjg_pkg::tern_t  td [ND+1];
  logic [NF:0]     dv;
  hjg_pkg::div_t   dd [NF+1];

  // x axis: bit reversal and a fixed shift, done at entry and carried along.
  logic [hjg_pkg::INDEX_BITS-1:0]                    rev;
  logic [hjg_pkg::INDEX_BITS+hjg_pkg::FRAC_BITS-1:0] xwide;
  logic [hjg_pkg::FRAC_BITS-1:0]                     xq;
  logic [hjg_pkg::CENTRE_W-1:0]                      xc;
  logic [hjg_pkg::CENTRE_W-1:0]                      yc;

  always_comb begin
    for (int k = 0; k < hjg_pkg::INDEX_BITS; k++) begin
      rev[k] = sample_index_i[hjg_pkg::INDEX_BITS-1-k];
    end
    // floor(rev * 2^F / 2^I)
    xwide = {rev, {hjg_pkg::FRAC_BITS{1'b0}}} >> hjg_pkg::INDEX_BITS;
    xq    = hjg_pkg::FRAC_BITS'(xwide);
    xc    = hjg_pkg::CENTRE_W'(xq)
          - (hjg_pkg::CENTRE_W'(1) << (hjg_pkg::FRAC_BITS - 1));
  end

  assign en         = !dv[NF] || !out_stall_i;
  assign in_stall_o = !en;

  assign tv[0]      = in_valid_i;
  assign td[0].v    = sample_index_i;
  assign td[0].tnum = '0;
  assign td[0].jx   = hjg_pkg::OUT_BITS'(xc);

  // Digit cells: lowest ternary digit first, mirrored into tnum.
  for (genvar i = 0; i < ND; i++) begin : g_tern
    hjg_tern_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (tv[i]),
      .data_i  (td[i]),
      .valid_o (tv[i+1]),
      .data_o  (td[i+1])
    );
  end

  // Division seed: tnum < 3^20 always holds after the last digit.
  assign dv[0]     = tv[ND];
  assign dd[0].rem = td[ND].tnum;
  assign dd[0].q   = '0;
  assign dd[0].jx  = td[ND].jx;

  // Division cells: one quotient bit each, MSB first.
  for (genvar j = 0; j < NF; j++) begin : g_div
    hjg_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .data_i  (dd[j]),
      .valid_o (dv[j+1]),
      .data_o  (dd[j+1])
    );
  end

  // Centre y on zero; wraps into the output width when FRAC_BITS is wide.
  assign yc = hjg_pkg::CENTRE_W'(dd[NF].q)
            - (hjg_pkg::CENTRE_W'(1) << (hjg_pkg::FRAC_BITS - 1));

  assign out_valid_o = dv[NF];
  assign jitter_x_o  = dd[NF].jx;
  assign jitter_y_o  = hjg_pkg::OUT_BITS'(yc);

endmodule

`default_nettype wire

### test/halton_jitter_generator_top_tb.sv
// ----------------------------------------------------------------------------
// halton_jitter_generator_top_tb - self-checking bench for the jitter pipeline
// Drives sample indices through valid/stall, predicts each centred
// base-2 / base-3 radical inverse pair and checks every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Holds the pairs still owed by the pipeline, oldest first.
class JitterScoreboard;

  typedef struct packed {
    logic [hjg_pkg::INDEX_BITS-1:0] idx;
    logic [hjg_pkg::OUT_BITS-1:0]   jx;
    logic [hjg_pkg::OUT_BITS-1:0]   jy;
  } pair_t;

  pair_t pending_pairs[$];
  int    mismatches;
  int    pairs_checked;

  function new();
    mismatches    = 0;
    pairs_checked = 0;
  endfunction

  // floor(num * 2^FRAC_BITS / den) by restoring division, num < den
  function logic [63:0] scaled_fraction(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    int          k;
    rem = num;
    q   = '0;
    for (k = 0; k < hjg_pkg::FRAC_BITS; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // subtract one half, wrap into the output width
  function logic [hjg_pkg::OUT_BITS-1:0] centred(logic [63:0] q);
    return hjg_pkg::OUT_BITS'(q - (64'd1 << (hjg_pkg::FRAC_BITS - 1)));
  endfunction

  function void radical_inverse_pair(input logic [hjg_pkg::INDEX_BITS-1:0] idx,
                                     output logic [hjg_pkg::OUT_BITS-1:0] jx,
                                     output logic [hjg_pkg::OUT_BITS-1:0] jy);
    logic [63:0] reversed;
    logic [63:0] mirrored;
    logic [63:0] rest;
    logic [63:0] tern_den;
    int          k;
    // base 2: bit reversal over the index width
    reversed = '0;
    rest     = 64'(idx);
    for (k = 0; k < hjg_pkg::INDEX_BITS; k++) begin
      reversed = {reversed[62:0], rest[0]};
      rest     = rest >> 1;
    end
    // base 3: twenty ternary digits mirrored about the point, over 3^20
    mirrored = '0;
    tern_den = 64'd1;
    rest     = 64'(idx);
    for (k = 0; k < 20; k++) begin
      mirrored = mirrored * 64'd3 + (rest % 64'd3);
      rest     = rest / 64'd3;
      tern_den = tern_den * 64'd3;
    end
    jx = centred(scaled_fraction(reversed, 64'd1 << hjg_pkg::INDEX_BITS));
    jy = centred(scaled_fraction(mirrored, tern_den));
  endfunction

  function void note_index(logic [hjg_pkg::INDEX_BITS-1:0] idx);
    pair_t p;
    p.idx = idx;
    radical_inverse_pair(idx, p.jx, p.jy);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function void check_pair(logic [hjg_pkg::OUT_BITS-1:0] jx,
                           logic [hjg_pkg::OUT_BITS-1:0] jy);
    pair_t p;
    if (pending_pairs.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output beat x=%0d y=%0d", $time,
               $signed(jx), $signed(jy));
      return;
    end
    p = pending_pairs.pop_front();
    pairs_checked++;
    if (jx !== p.jx) begin
      mismatches++;
      $display("%0t: index %0d jitter_x expected %0d got %0d", $time, p.idx,
               $signed(p.jx), $signed(jx));
    end
    if (jy !== p.jy) begin
      mismatches++;
      $display("%0t: index %0d jitter_y expected %0d got %0d", $time, p.idx,
               $signed(p.jy), $signed(jy));
    end
  endfunction

  function int pending();
    return pending_pairs.size();
  endfunction

endclass

module halton_jitter_generator_top_tb;

  // Final drain, well past the pipeline depth at the defaults.
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 445;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [hjg_pkg::INDEX_BITS-1:0]       sample_index_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic signed [hjg_pkg::OUT_BITS-1:0]  jitter_x_o;
  logic signed [hjg_pkg::OUT_BITS-1:0]  jitter_y_o;

  JitterScoreboard jitter_sb = new();

  // Idle rates in percent, changed between phases by the stimulus thread.
  int in_idle_pct;
  int out_stall_pct;
  int indices_sent;

  halton_jitter_generator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_index_i (sample_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .jitter_x_o     (jitter_x_o),
    .jitter_y_o     (jitter_y_o)
  );

  // 2 ns clock: rising edges at odd ns, falling at even ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver side: a fresh stall decision every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Output monitor: a beat is taken when valid is high and stall low at the
  // rising edge. Values seen here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      jitter_sb.check_pair(jitter_x_o, jitter_y_o);
    end
  end

  // Presents one index, after any random idle cycles, and holds it until the
  // pipeline takes the beat. Called and returns at a falling edge.
  task automatic send_index(input logic [hjg_pkg::INDEX_BITS-1:0] idx);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    jitter_sb.note_index(idx);
    indices_sent++;
    @(negedge clk_i);
  endtask

  // Holds the input quiet until every owed pair has come out.
  task automatic drain_pipeline();
    while (jitter_sb.pending() != 0) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Mostly uniform indices; some small ones, some near powers of three,
  // where the ternary digits carry a long way, and some at the top of the range.
  function automatic logic [hjg_pkg::INDEX_BITS-1:0] random_index();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      return hjg_pkg::INDEX_BITS'($urandom);
    end else if (pick < 88) begin
      return hjg_pkg::INDEX_BITS'($urandom_range(0, 63));
    end else begin
      case ($urandom_range(0, 3))
        0:       return hjg_pkg::INDEX_BITS'(6561 + $urandom_range(0, 2) - 1);
        1:       return hjg_pkg::INDEX_BITS'(19683 + $urandom_range(0, 2) - 1);
        2:       return hjg_pkg::INDEX_BITS'(59049 + $urandom_range(0, 2) - 1);
        default: return hjg_pkg::INDEX_BITS'(65535 - $urandom_range(0, 7));
      endcase
    end
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input bit pause_midway);
    int i;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain_pipeline();
      send_index(random_index());
    end
  endtask

  initial begin
    logic [hjg_pkg::INDEX_BITS-1:0] corner_idx[$];
    int                             i;
    corner_idx = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd27, 16'd81,
                   16'd6561, 16'd19683, 16'd59048, 16'd59049, 16'd59050,
                   16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                   16'h1234, 16'hFFFE, 16'hFFFF, 16'd0};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_index_i = '0;
    out_stall_i    = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    indices_sent   = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners back to back: zero, all ones, single bits, alternating
    // patterns and indices either side of powers of three.
    for (i = 0; i < corner_idx.size(); i++) send_index(corner_idx[i]);

    // Random phases: free flow, sender gaps, receiver back-pressure, both.
    run_phase(PHASE_ITEMS, 0, 0, 1'b0);
    run_phase(PHASE_ITEMS, 75, 0, 1'b1);
    run_phase(PHASE_ITEMS, 0, 75, 1'b0);
    run_phase(PHASE_ITEMS, 16, 16, 1'b0);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    drain_pipeline();
    out_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d indices (corners plus four idle/stall mixes), checked %0d pairs,",
             indices_sent, jitter_sb.pairs_checked);
    $display("  %0d mismatches, %0d pairs never returned.", jitter_sb.mismatches,
             jitter_sb.pending());
    if (jitter_sb.mismatches == 0 && jitter_sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Timed out with %0d pairs outstanding.", jitter_sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
src/hjg_pkg.sv
src/hjg_tern_cell.sv
src/hjg_div_cell.sv
src/halton_jitter_generator_top.sv
test/halton_jitter_generator_top_tb.sv
